// ===== design/tpq_pkg.sv =====
package tpq_pkg;

  // Default ring depth of each class queue
  localparam int unsigned QueueDepthDef = 16;

  // Field widths
  localparam int unsigned ValW  = 16;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 3;
  localparam int unsigned PosW  = 4;

  // Threshold value after reset
  localparam logic signed [ValW-1:0] ThreshReset = 16'sd60;

  // Command codes
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_MODIFY = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] RES_INSERTED  = 3'd0;
  localparam logic [StatW-1:0] RES_FULL      = 3'd1;
  localparam logic [StatW-1:0] RES_REMOVED   = 3'd2;
  localparam logic [StatW-1:0] RES_EMPTY     = 3'd3;
  localparam logic [StatW-1:0] RES_MODIFIED  = 3'd4;
  localparam logic [StatW-1:0] RES_NOT_FOUND = 3'd5;
  localparam logic [StatW-1:0] RES_MISMATCH  = 3'd6;

  // Input item
  typedef struct packed {
    logic [CmdW-1:0]        command;
    logic signed [ValW-1:0] value;
    logic signed [ValW-1:0] new_value;
  } item_t;

  // Result item
  typedef struct packed {
    logic [StatW-1:0]       status;
    logic signed [ValW-1:0] removed_value;
    logic                   from_high;
    logic [PosW-1:0]        position;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             insert;
    logic             remove;
    logic             scan_start;
    logic             scan_step;
    logic             modify;
    logic             res_en;
    logic [StatW-1:0] res_status;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CmdW-1:0] command;
    logic            mismatch;
    logic            high_nonempty;
    logic            low_nonempty;
    logic            tgt_full;
    logic            tgt_empty;
    logic            match;
    logic            scan_last;
  } dp_stat_t;

endpackage

// ===== design/two_class_priority_queue.sv =====
// Flow: an accepted item is loaded and then decoded; insert, full, empty, class mismatch and modify
// on an empty class report from the decode state; remove reports from the remove state; a modify
// scans its class from the head, one entry per cycle, and reports at the first match or after the
// last live entry. An unused command gives no result. The result strobe is registered.
// Throughput: a new item is taken at the edge that ends the strobe cycle; results cannot stall.
// Reset: heads and counts clear, threshold returns to 60; stores are not cleared.
module two_class_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = tpq_pkg::QueueDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  tpq_pkg::item_t                  item_i,
  output logic                            busy,
  input  logic                            cfg_we_i,
  input  logic signed [tpq_pkg::ValW-1:0] cfg_wdata_i,
  output logic                            result_valid_o,
  output tpq_pkg::result_t                result_o
);
  import tpq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  tpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // An accepted item keeps the block occupied for the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // At most one result per item: strobes never come back to back
  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // Removed value is zero unless a remove succeeded
  a_removed_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != RES_REMOVED) |->
      (result_o.removed_value == '0))
    else $error("removed value set on a result that is not a remove");

  // The controller is back in idle whenever a result is presented
  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while an item is still in flight");

endmodule

// ===== design/tpq_ctrl.sv =====
module tpq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tpq_pkg::dp_stat_t    stat_i,
  output tpq_pkg::ctrl_cmd_t   cmd_o,
  output logic                 busy_o
);
  import tpq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_REMOVE = 2'd2;
  localparam logic [1:0] S_SCAN   = 2'd3;

  logic [1:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (stat_i.command)
          CMD_INSERT: begin
            cmd_o.res_en = 1'b1;
            if (stat_i.tgt_full) begin
              cmd_o.res_status = RES_FULL;
            end else begin
              cmd_o.insert     = 1'b1;
              cmd_o.res_status = RES_INSERTED;
            end
          end
          CMD_REMOVE: begin
            if (stat_i.high_nonempty || stat_i.low_nonempty) begin
              cmd_o.remove = 1'b1;
              state_d      = S_REMOVE;
            end else begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = RES_EMPTY;
            end
          end
          CMD_MODIFY: begin
            if (stat_i.mismatch) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = RES_MISMATCH;
            end else if (stat_i.tgt_empty) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = RES_NOT_FOUND;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
            // unused code: nothing to report
            state_d = S_IDLE;
          end
        endcase
      end
      S_REMOVE: begin
        cmd_o.res_en     = 1'b1;
        cmd_o.res_status = RES_REMOVED;
        state_d          = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.modify     = 1'b1;
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = RES_MODIFIED;
          state_d          = S_IDLE;
        end else if (stat_i.scan_last) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = RES_NOT_FOUND;
          state_d          = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== design/tpq_dp.sv =====
module tpq_dp #(
  parameter int unsigned QUEUE_DEPTH = tpq_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tpq_pkg::ctrl_cmd_t            cmd_i,
  input  tpq_pkg::item_t                item_i,
  input  logic                          cfg_we_i,
  input  logic signed [tpq_pkg::ValW-1:0] cfg_wdata_i,
  output tpq_pkg::dp_stat_t             stat_o,
  output logic                          result_valid_o,
  output tpq_pkg::result_t              result_o
);
  import tpq_pkg::*;

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;

  // Ring add with wrap; both operands stay below the depth
  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] a,
                                               input logic [IdxW-1:0] b);
    logic [SumW-1:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SumW'(QUEUE_DEPTH)) begin
      sum = sum - SumW'(QUEUE_DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  item_t                  item_q;
  logic signed [ValW-1:0] thr_q;
  logic [IdxW-1:0]        hh_q, hh_d, lh_q, lh_d;
  logic [CntW-1:0]        hc_q, hc_d, lc_q, lc_d;
  logic                   sel_hi_q, sel_hi_d;
  logic [IdxW-1:0]        scan_idx_q, scan_idx_d;
  logic [IdxW-1:0]        scan_off_q, scan_off_d;
  logic [ValW-1:0]        mem_h [QUEUE_DEPTH];
  logic [ValW-1:0]        mem_l [QUEUE_DEPTH];
  logic [ValW-1:0]        rd_h_q, rd_l_q;
  result_t                res_q;
  logic                   res_valid_q;

  logic                   item_hi, new_hi;
  logic [IdxW-1:0]        tgt_head, tail_idx, scan_next, raddr, waddr;
  logic [CntW-1:0]        tgt_cnt;
  logic [ValW-1:0]        rd_sel, wdata;
  logic                   we_h, we_l;
  logic [CntW-1:0]        scan_cnt;

  // Classification and target queue
  assign item_hi   = (item_q.value > thr_q);
  assign new_hi    = (item_q.new_value > thr_q);
  assign tgt_head  = item_hi ? hh_q : lh_q;
  assign tgt_cnt   = item_hi ? hc_q : lc_q;
  assign tail_idx  = wrap_add(tgt_head, tgt_cnt[IdxW-1:0]);
  assign scan_next = wrap_add(scan_idx_q, IdxW'(1));
  assign rd_sel    = sel_hi_q ? rd_h_q : rd_l_q;
  assign scan_cnt  = {{(CntW-IdxW){1'b0}}, scan_off_q} + CntW'(1);

  // Status towards the controller
  always_comb begin
    stat_o.command       = item_q.command;
    stat_o.mismatch      = (item_hi != new_hi);
    stat_o.high_nonempty = (hc_q != '0);
    stat_o.low_nonempty  = (lc_q != '0);
    stat_o.tgt_full      = (tgt_cnt == CntW'(QUEUE_DEPTH));
    stat_o.tgt_empty     = (tgt_cnt == '0);
    stat_o.match         = (rd_sel == item_q.value);
    stat_o.scan_last     = (scan_cnt == (sel_hi_q ? hc_q : lc_q));
  end

  // Pointer, count and scan updates
  always_comb begin
    hh_d       = hh_q;
    lh_d       = lh_q;
    hc_d       = hc_q;
    lc_d       = lc_q;
    sel_hi_d   = sel_hi_q;
    scan_idx_d = scan_idx_q;
    scan_off_d = scan_off_q;
    raddr      = scan_next;
    if (cmd_i.insert) begin
      if (item_hi) begin
        hc_d = hc_q + CntW'(1);
      end else begin
        lc_d = lc_q + CntW'(1);
      end
    end
    if (cmd_i.remove) begin
      if (hc_q != '0) begin
        sel_hi_d = 1'b1;
        raddr    = hh_q;
        hh_d     = wrap_add(hh_q, IdxW'(1));
        hc_d     = hc_q - CntW'(1);
      end else begin
        sel_hi_d = 1'b0;
        raddr    = lh_q;
        lh_d     = wrap_add(lh_q, IdxW'(1));
        lc_d     = lc_q - CntW'(1);
      end
    end
    if (cmd_i.scan_start) begin
      sel_hi_d   = item_hi;
      raddr      = tgt_head;
      scan_idx_d = tgt_head;
      scan_off_d = '0;
    end
    if (cmd_i.scan_step) begin
      scan_idx_d = scan_next;
      scan_off_d = scan_off_q + IdxW'(1);
    end
  end

  // Store write port: insert at tail or replace the matched entry
  always_comb begin
    we_h  = 1'b0;
    we_l  = 1'b0;
    waddr = tail_idx;
    wdata = item_q.value;
    if (cmd_i.insert) begin
      we_h = item_hi;
      we_l = !item_hi;
    end else if (cmd_i.modify) begin
      we_h  = sel_hi_q;
      we_l  = !sel_hi_q;
      waddr = scan_idx_q;
      wdata = item_q.new_value;
    end
  end

  // Class stores, registered read
  always_ff @(posedge clk_i) begin
    if (we_h) begin
      mem_h[waddr] <= wdata;
    end
    rd_h_q <= mem_h[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_l) begin
      mem_l[waddr] <= wdata;
    end
    rd_l_q <= mem_l[raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThreshReset;
      hh_q        <= '0;
      lh_q        <= '0;
      hc_q        <= '0;
      lc_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      hh_q        <= hh_d;
      lh_q        <= lh_d;
      hc_q        <= hc_d;
      lc_q        <= lc_d;
      res_valid_q <= cmd_i.res_en;
    end
  end

  // Item, scan and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    sel_hi_q   <= sel_hi_d;
    scan_idx_q <= scan_idx_d;
    scan_off_q <= scan_off_d;
    if (cmd_i.res_en) begin
      res_q.status        <= cmd_i.res_status;
      res_q.removed_value <= (cmd_i.res_status == RES_REMOVED) ? rd_sel : '0;
      if (cmd_i.res_status == RES_INSERTED) begin
        res_q.from_high <= item_hi;
      end else if (cmd_i.res_status == RES_REMOVED ||
                   cmd_i.res_status == RES_MODIFIED) begin
        res_q.from_high <= sel_hi_q;
      end else begin
        res_q.from_high <= 1'b0;
      end
      res_q.position <= (cmd_i.res_status == RES_MODIFIED) ?
                        PosW'(scan_off_q) : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tpq_pkg::*;

  localparam int unsigned DEPTH     = QueueDepthDef;
  localparam int          LIMIT     = 300000;
  // Settle time covers the longest modify scan, with margin
  localparam int          SETTLE    = 2 * DEPTH + 8;
  localparam int          PHASE_ITEMS = 150;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    item_t   it;
    int      reps;
    bit      typed;
    result_t res;
  } script_row_t;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start;
  item_t                  item_i;
  logic                   busy;
  logic                   cfg_we_i;
  logic signed [ValW-1:0] cfg_wdata_i;
  logic                   result_valid_o;
  result_t                result_o;

  // Shadow of both class rings and the threshold
  logic signed [ValW-1:0] ring_slot [2][DEPTH];
  int                     ring_head [2];
  int                     ring_fill [2];
  logic signed [ValW-1:0] threshold = ThreshReset;

  result_t     pending_outcomes [$];
  script_row_t script [$];
  int          errors;
  int          cycle_count;
  int          n_items;
  int          n_settings;
  int          idle_pct = 22;
  int          status_seen [7];

  two_class_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", LIMIT,
               pending_outcomes.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Apply one command to the shadow queues; returns 0 when no result follows
  function automatic bit serve_command(input item_t it, output result_t res);
    int cls;
    int i;
    int k;
    bit found;
    res = '0;
    case (it.command)
      CMD_INSERT: begin
        cls = ($signed(it.value) > threshold) ? 1 : 0;
        if (ring_fill[cls] >= DEPTH) begin
          res.status = RES_FULL;
        end else begin
          ring_slot[cls][(ring_head[cls] + ring_fill[cls]) % DEPTH] = it.value;
          ring_fill[cls]++;
          res.status    = RES_INSERTED;
          res.from_high = cls[0];
        end
      end
      CMD_REMOVE: begin
        if (ring_fill[1] != 0 || ring_fill[0] != 0) begin
          // high class always drains first
          cls = (ring_fill[1] != 0) ? 1 : 0;
          res.status        = RES_REMOVED;
          res.removed_value = ring_slot[cls][ring_head[cls]];
          res.from_high     = cls[0];
          ring_head[cls]    = (ring_head[cls] + 1) % DEPTH;
          ring_fill[cls]--;
        end else begin
          res.status = RES_EMPTY;
        end
      end
      CMD_MODIFY: begin
        cls = ($signed(it.value) > threshold) ? 1 : 0;
        if (($signed(it.new_value) > threshold) != cls[0]) begin
          res.status = RES_MISMATCH;
        end else begin
          // first live match from the head wins
          res.status = RES_NOT_FOUND;
          found = 1'b0;
          for (i = 0; i < ring_fill[cls] && !found; i++) begin
            k = (ring_head[cls] + i) % DEPTH;
            if (ring_slot[cls][k] == it.value) begin
              ring_slot[cls][k] = it.new_value;
              found             = 1'b1;
              res.status        = RES_MODIFIED;
              res.from_high     = cls[0];
              res.position      = i[PosW-1:0];
            end
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic script_row_t row(input logic [CmdW-1:0] cmd,
                                      input logic signed [ValW-1:0] v,
                                      input logic signed [ValW-1:0] nv,
                                      input int reps, input bit typed,
                                      input logic [StatW-1:0] st = RES_INSERTED,
                                      input logic signed [ValW-1:0] rv = '0,
                                      input logic fh = 1'b0,
                                      input logic [PosW-1:0] pos = '0);
    script_row_t r;
    r.it.command         = cmd;
    r.it.value           = v;
    r.it.new_value       = nv;
    r.reps               = reps;
    r.typed              = typed;
    r.res.status         = st;
    r.res.removed_value  = rv;
    r.res.from_high      = fh;
    r.res.position       = pos;
    return r;
  endfunction

  // Random value inside one class, biased to its edges
  function automatic logic signed [ValW-1:0] in_class(input bit hi);
    int lo_b;
    int hi_b;
    if (hi) begin
      lo_b = threshold + 1;
      hi_b = 32767;
    end else begin
      lo_b = -32768;
      hi_b = threshold;
    end
    if (lo_b > hi_b) return ValW'($urandom);  // class cannot hold anything
    case ($urandom_range(3))
      0:       return ValW'(hi ? lo_b : hi_b);
      1:       return ValW'(hi ? hi_b : lo_b);
      default: return ValW'(lo_b + int'($urandom_range(hi_b - lo_b)));
    endcase
  endfunction

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(9))
      0, 1:    return in_class(1'b1);
      2, 3:    return in_class(1'b0);
      // tight pool around the threshold gives duplicates and boundary hits
      4, 5, 6: return ValW'(threshold + int'($urandom_range(6)) - 3);
      default: return ValW'($urandom);
    endcase
  endfunction

  function automatic item_t random_command(input bit filling);
    item_t it;
    int    r;
    int    cls;
    int    off;
    it.value     = pick_value();
    it.new_value = pick_value();
    r = int'($urandom_range(99));
    if (r < 4) begin
      it.command = CMD_UNUSED;
    end else if (r < (filling ? 60 : 30)) begin
      it.command = CMD_INSERT;
    end else if (r < 75) begin
      it.command = CMD_REMOVE;
    end else begin
      it.command = CMD_MODIFY;
      cls = int'($urandom_range(1));
      // aim at a live entry half the time
      if (ring_fill[cls] != 0 && $urandom_range(1) == 1) begin
        off      = int'($urandom_range(ring_fill[cls] - 1));
        it.value = ring_slot[cls][(ring_head[cls] + off) % DEPTH];
      end
      if ($urandom_range(3) != 0)
        it.new_value = in_class($signed(it.value) > threshold);
    end
    return it;
  endfunction

  // One transfer into the block, with random sender gaps
  task automatic issue(input item_t it, input bit typed, input result_t typed_res);
    result_t res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (serve_command(it, res))
      pending_outcomes.push_back(typed ? typed_res : res);
    n_items++;
  endtask

  // Threshold is only rewritten once the block has gone quiet
  task automatic set_threshold(input logic signed [ValW-1:0] v);
    start <= 1'b0;
    while (pending_outcomes.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    threshold = v;
    n_settings++;
  endtask

  function automatic void check_field(input string name,
                                      input logic signed [ValW-1:0] want_v,
                                      input logic signed [ValW-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, result_o);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", want.status, result_o.status);
        check_field("removed_value", want.removed_value, result_o.removed_value);
        check_field("from_high", want.from_high, result_o.from_high);
        check_field("position", want.position, result_o.position);
      end
      if (result_o.status <= RES_MISMATCH) status_seen[result_o.status]++;
    end
  end

  initial begin
    item_t it;
    int    ph;
    int    issued;
    int    burst;
    bit    filling;
    logic signed [ValW-1:0] next_thr;

    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;

    // Directed script, reset threshold of 60
    script.push_back(row(CMD_REMOVE, 16'sd0, 16'sd0, 1, 1'b1, RES_EMPTY));
    script.push_back(row(CMD_MODIFY, 16'sd5, 16'sd7, 1, 1'b1, RES_NOT_FOUND));
    script.push_back(row(CMD_INSERT, 16'sh7fff, -16'sd1, 1, 1'b1, RES_INSERTED, 16'sd0,
                         1'b1));
    script.push_back(row(CMD_INSERT, 16'sh8000, 16'sh7fff, 1, 1'b1, RES_INSERTED));
    script.push_back(row(CMD_INSERT, 16'sd60, 16'sd0, 1, 1'b1, RES_INSERTED));
    script.push_back(row(CMD_INSERT, 16'sd61, 16'sd0, 1, 1'b1, RES_INSERTED, 16'sd0,
                         1'b1));
    script.push_back(row(CMD_INSERT, 16'sd60, 16'sd0, 1, 1'b1, RES_INSERTED));
    // duplicate 60: only the first from the head changes
    script.push_back(row(CMD_MODIFY, 16'sd60, -16'sd1, 1, 1'b1, RES_MODIFIED, 16'sd0,
                         1'b0, 4'd1));
    script.push_back(row(CMD_MODIFY, 16'sd61, 16'sd60, 1, 1'b1, RES_MISMATCH));
    script.push_back(row(CMD_UNUSED, 16'sh7fff, 16'sh8000, 1, 1'b0));
    script.push_back(row(CMD_REMOVE, 16'sd0, 16'sd0, 1, 1'b1, RES_REMOVED, 16'sh7fff,
                         1'b1));
    // fill the high ring to the brim
    script.push_back(row(CMD_INSERT, 16'sd100, 16'sd0, 14, 1'b1, RES_INSERTED, 16'sd0,
                         1'b1));
    script.push_back(row(CMD_INSERT, 16'sd32766, 16'sd0, 1, 1'b1, RES_INSERTED, 16'sd0,
                         1'b1));
    script.push_back(row(CMD_INSERT, 16'sd200, 16'sd0, 1, 1'b1, RES_FULL));
    script.push_back(row(CMD_MODIFY, 16'sd32766, 16'sd1000, 1, 1'b1, RES_MODIFIED,
                         16'sd0, 1'b1, 4'd15));
    script.push_back(row(CMD_MODIFY, 16'sd60, 16'sh8000, 1, 1'b0));
    script.push_back(row(CMD_REMOVE, 16'sd0, 16'sd0, 2, 1'b0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r])
      repeat (script[r].reps) issue(script[r].it, script[r].typed, script[r].res);

    // Random phases, each under its own threshold
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       next_thr = 16'sh8000;
        1:       next_thr = 16'sh7fff;
        2:       next_thr = 16'sd0;
        3:       next_thr = -16'sd1;
        default: next_thr = ValW'($urandom);
      endcase
      set_threshold(next_thr);
      idle_pct = (ph < 2) ? 22 : (ph < 4) ? 60 : 0;
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        filling = 1'($urandom_range(1));
        burst   = int'($urandom_range(60, 30));
        for (int b = 0; b < burst && issued < PHASE_ITEMS; b++) begin
          it = random_command(filling);
          issue(it, 1'b0, '0);
          issued++;
        end
      end
    end

    // Drain
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Ran %0d commands under %0d threshold settings plus the reset value, %0d errors",
             n_items, n_settings, errors);
    $display("Status counts ins/full/rem/empty/mod/notfound/mismatch: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
